>>> rtl/nearest_timestamp_frame_cache_defines.svh
// Assertion macros for the nearest-timestamp frame cache checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef NEAREST_TIMESTAMP_FRAME_CACHE_DEFINES_SVH
`define NEAREST_TIMESTAMP_FRAME_CACHE_DEFINES_SVH

// Same-cycle implication, off while reset is held.
`define NFTC_AST_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off while reset is held.
`define NFTC_AST_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/nftc_pkg.sv
// Shared types, widths and request codes for the nearest-timestamp frame cache.
// No dependencies; rtl files use scoped names, the testbench imports it.
package nftc_pkg;

  localparam int PTS_W    = 48;
  localparam int HANDLE_W = 16;
  localparam int DUR_W    = 24;
  localparam int TOL_W    = DUR_W - 1;
  localparam int DIST_W   = PTS_W + 1;

  localparam int CACHE_DEPTH_DEF = 8;

  localparam logic [TOL_W-1:0] DEFAULT_TOL_US = TOL_W'(20000);

  localparam logic [1:0] REQ_LOOKUP = 2'd0;
  localparam logic [1:0] REQ_STORE  = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  typedef struct packed {
    logic [1:0]                 req_type;
    logic signed [PTS_W-1:0]    pts_us;
    logic [HANDLE_W-1:0]        image_handle;
    logic                       image_present;
  } nftc_req_t;

  typedef struct packed {
    logic                       hit;
    logic [HANDLE_W-1:0]        found_handle;
  } nftc_res_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan_start;
    logic upd_start;
    logic rd_en;
    logic occ_clr;
    logic occ_inc;
    logic finish;
  } nftc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic idx_end;
    logic pipe_busy;
    logic match_found;
    logic full;
  } nftc_stat_t;

endpackage

>>> rtl/nftc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module nftc_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 8,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/nftc_ctrl.sv
// Request sequencer for the frame cache: scan pass, optional update pass, result.
// Depends on nftc_pkg for request codes and the command/status structs.
module nftc_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [1:0]             req_type,
  input  logic                   image_present,
  input  nftc_pkg::nftc_stat_t   stat,
  output nftc_pkg::nftc_cmd_t    cmd,
  output logic                   busy
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_SDRAIN = 3'd2;
  localparam logic [2:0] S_UPD    = 3'd3;
  localparam logic [2:0] S_UDRAIN = 3'd4;
  localparam logic [2:0] S_FIN    = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [1:0] op_r, op_nxt;
  logic       pres_r, pres_nxt;
  logic       do_store;

  assign do_store = (op_r == nftc_pkg::REQ_STORE) && pres_r;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    pres_nxt  = pres_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load       = 1'b1;
          cmd.scan_start = 1'b1;
          op_nxt         = req_type;
          pres_nxt       = image_present;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!stat.idx_end) begin
          cmd.rd_en = 1'b1;
        end else begin
          state_nxt = S_SDRAIN;
        end
      end
      S_SDRAIN: begin
        if (!stat.pipe_busy) begin
          if (do_store) begin
            cmd.upd_start = 1'b1;
            state_nxt     = S_UPD;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_UPD: begin
        if (!stat.idx_end) begin
          cmd.rd_en = 1'b1;
        end else begin
          state_nxt = S_UDRAIN;
        end
      end
      S_UDRAIN: begin
        if (!stat.pipe_busy) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.finish  = 1'b1;
        cmd.occ_clr = (op_r == nftc_pkg::REQ_CLEAR);
        // a new timestamp grows the cache until it is full
        cmd.occ_inc = do_store && !stat.match_found && !stat.full;
        state_nxt   = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= nftc_pkg::REQ_LOOKUP;
      pres_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      pres_r  <= pres_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

>>> rtl/nftc_dp.sv
// Frame cache datapath: entry RAM, scan pipeline, nearest tracking, rank update.
// Depends on nftc_pkg and nftc_ram.
module nftc_dp #(
  parameter int DEPTH = nftc_pkg::CACHE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [nftc_pkg::DUR_W-1:0]    cfg_wdata,
  input  nftc_pkg::nftc_req_t           in_req,
  input  nftc_pkg::nftc_cmd_t           cmd,
  output nftc_pkg::nftc_stat_t          stat,
  output logic                          out_valid,
  output nftc_pkg::nftc_res_t           out_res
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OW = $clog2(DEPTH + 1);
  localparam int PW = nftc_pkg::PTS_W;
  localparam int HW = nftc_pkg::HANDLE_W;
  localparam int DW = nftc_pkg::DIST_W;
  localparam int TW = nftc_pkg::TOL_W;
  localparam int EW = PW + HW + AW;
  localparam logic [AW-1:0] LAST_RANK = AW'(DEPTH - 1);

  // configuration and request
  logic [nftc_pkg::DUR_W-1:0] dur_r;
  logic [TW-1:0]              tol_calc;
  logic [TW-1:0]              tol_r;
  nftc_pkg::nftc_req_t        req_r;

  // sequencing
  logic [OW-1:0] occ_r;
  logic [OW-1:0] idx_r;
  logic          upd_r;
  logic [OW-1:0] limit;
  logic          full;
  logic          ins_new;

  // RAM
  logic [EW-1:0] rd_word;
  logic [EW-1:0] wr_word;
  logic          wr_en;
  logic [PW-1:0] e_pts;
  logic [HW-1:0] e_handle;
  logic [AW-1:0] e_rank;

  // stage 1: read data valid
  logic          s1_vld_r;
  logic          s1_upd_r;
  logic [AW-1:0] s1_idx_r;
  logic signed [DW-1:0] e_s, q_s, d_pos, d_neg;
  logic [DW-1:0] abs_d;
  logic          s1_scan;

  // stage 2: distance registered
  logic          s2_vld_r;
  logic [DW-1:0] s2_abs_r;
  logic [HW-1:0] s2_handle_r;
  logic [AW-1:0] s2_rank_r;
  logic          take;

  // scan results
  logic          found_r;
  logic [DW-1:0] best_r;
  logic [AW-1:0] best_rank_r;
  logic [HW-1:0] best_handle_r;
  logic          match_found_r;
  logic [AW-1:0] match_slot_r;
  logic [AW-1:0] match_rank_r;
  logic [AW-1:0] oldest_slot_r;

  // update target and pivot rank
  logic [AW-1:0] tgt_slot;
  logic [OW-1:0] pivot;
  logic          is_tgt;

  logic          res_hit;
  logic          out_valid_r;
  nftc_pkg::nftc_res_t out_res_r;

  always_comb begin
    if (dur_r == '0) begin
      tol_calc = nftc_pkg::DEFAULT_TOL_US;
    end else if (dur_r[nftc_pkg::DUR_W-1:1] == '0) begin
      tol_calc = TW'(1);
    end else begin
      tol_calc = dur_r[nftc_pkg::DUR_W-1:1];
    end
  end

  assign full    = (occ_r == OW'(DEPTH));
  assign ins_new = !match_found_r && !full;
  assign limit   = upd_r ? (occ_r + OW'(ins_new)) : occ_r;

  assign stat.idx_end     = (idx_r == limit);
  assign stat.pipe_busy   = s1_vld_r | s2_vld_r;
  assign stat.match_found = match_found_r;
  assign stat.full        = full;

  nftc_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH),
    .ADDR_W(AW)
  ) u_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(s1_idx_r),
    .wdata(wr_word),
    .re   (cmd.rd_en),
    .raddr(idx_r[AW-1:0]),
    .rdata(rd_word)
  );

  assign e_pts    = rd_word[EW-1 -: PW];
  assign e_handle = rd_word[AW +: HW];
  assign e_rank   = rd_word[AW-1:0];

  // both differences in parallel, pick the non-negative one
  assign e_s     = {e_pts[PW-1], e_pts};
  assign q_s     = {req_r.pts_us[PW-1], req_r.pts_us};
  assign d_pos   = e_s - q_s;
  assign d_neg   = q_s - e_s;
  assign abs_d   = d_pos[DW-1] ? d_neg : d_pos;
  assign s1_scan = s1_vld_r && !s1_upd_r;

  // ties go to the lower rank, which is the more recent entry
  assign take = s2_vld_r && (s2_abs_r <= DW'(tol_r)) &&
                ((s2_abs_r < best_r) ||
                 ((s2_abs_r == best_r) && (s2_rank_r < best_rank_r)));

  always_comb begin
    if (match_found_r) begin
      tgt_slot = match_slot_r;
      pivot    = OW'(match_rank_r);
    end else if (full) begin
      tgt_slot = oldest_slot_r;
      pivot    = OW'(LAST_RANK);
    end else begin
      tgt_slot = occ_r[AW-1:0];
      pivot    = occ_r;
    end
  end

  assign is_tgt = (s1_idx_r == tgt_slot);

  always_comb begin
    wr_en   = 1'b0;
    wr_word = rd_word;
    if (s1_vld_r && s1_upd_r) begin
      if (is_tgt) begin
        wr_en = 1'b1;
        if (match_found_r) begin
          wr_word = {e_pts, e_handle, AW'(0)};
        end else begin
          wr_word = {req_r.pts_us, req_r.image_handle, AW'(0)};
        end
      end else if (OW'(e_rank) < pivot) begin
        // age every entry that was more recent than the one moving up
        wr_en   = 1'b1;
        wr_word = {e_pts, e_handle, e_rank + AW'(1)};
      end
    end
  end

  assign res_hit = (req_r.req_type == nftc_pkg::REQ_LOOKUP) && found_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dur_r         <= '0;
      occ_r         <= '0;
      idx_r         <= '0;
      upd_r         <= 1'b0;
      s1_vld_r      <= 1'b0;
      s2_vld_r      <= 1'b0;
      found_r       <= 1'b0;
      match_found_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        dur_r <= cfg_wdata;
      end
      if (cmd.occ_clr) begin
        occ_r <= '0;
      end else if (cmd.occ_inc) begin
        occ_r <= occ_r + OW'(1);
      end
      if (cmd.scan_start) begin
        idx_r <= '0;
        upd_r <= 1'b0;
      end else if (cmd.upd_start) begin
        idx_r <= '0;
        upd_r <= 1'b1;
      end else if (cmd.rd_en) begin
        idx_r <= idx_r + OW'(1);
      end
      s1_vld_r <= cmd.rd_en;
      s2_vld_r <= s1_scan;
      if (cmd.load) begin
        found_r       <= 1'b0;
        match_found_r <= 1'b0;
      end else begin
        if (take) begin
          found_r <= 1'b1;
        end
        if (s1_scan && (e_pts == req_r.pts_us)) begin
          match_found_r <= 1'b1;
        end
      end
      out_valid_r <= cmd.finish;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    s1_upd_r <= upd_r;
    s1_idx_r <= idx_r[AW-1:0];
    if (cmd.load) begin
      req_r  <= in_req;
      tol_r  <= tol_calc;
      best_r <= DW'(tol_calc) + DW'(1);
    end else if (take) begin
      best_r        <= s2_abs_r;
      best_rank_r   <= s2_rank_r;
      best_handle_r <= s2_handle_r;
    end
    if (s1_scan) begin
      s2_abs_r    <= abs_d;
      s2_handle_r <= e_handle;
      s2_rank_r   <= e_rank;
      if (e_pts == req_r.pts_us) begin
        match_slot_r <= s1_idx_r;
        match_rank_r <= e_rank;
      end
      if (e_rank == LAST_RANK) begin
        oldest_slot_r <= s1_idx_r;
      end
    end
    if (cmd.finish) begin
      out_res_r.hit          <= res_hit;
      out_res_r.found_handle <= res_hit ? best_handle_r : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

>>> rtl/nearest_timestamp_frame_cache.sv
// Nearest-timestamp frame cache, top level.
// Holds up to CACHE_DEPTH entries (timestamp, image handle) in a RAM, each with a
// recency rank; 0 is the most recent. Request channel: in_req is taken at a clock
// edge where start is high and busy is low. Request codes: lookup returns the
// handle of the entry nearest pts_us within the tolerance (half of
// frame_duration_us, at least 1, or 20000 when the duration is 0), the more
// recent entry winning ties; store moves an existing timestamp to the front or
// inserts a new entry, dropping the oldest when full; clear empties the cache.
// Every request gives exactly one result on out_res, shown for one cycle with
// out_valid high; the receiver cannot stall, so the result must be taken then.
// A lookup, clear or ignored request makes one pass over the entries held; a
// store with an image adds a second pass over the RAM. Both passes run on the
// single RAM read port, which visits one entry per cycle. busy is high from
// acceptance until the result appears, and the next request is taken in the
// cycle the result shows.
// cfg_we writes frame_duration_us (cfg_wdata); write it only while idle.
// Reset (rst_n low, synchronous) empties the cache and sets the duration to 0.
module nearest_timestamp_frame_cache #(
  parameter int CACHE_DEPTH = nftc_pkg::CACHE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  nftc_pkg::nftc_req_t           in_req,
  output logic                          out_valid,
  output nftc_pkg::nftc_res_t           out_res,
  input  logic                          cfg_we,
  input  logic [nftc_pkg::DUR_W-1:0]    cfg_wdata
);

  nftc_pkg::nftc_cmd_t  cmd;
  nftc_pkg::nftc_stat_t stat;

  nftc_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .req_type     (in_req.req_type),
    .image_present(in_req.image_present),
    .stat         (stat),
    .cmd          (cmd),
    .busy         (busy)
  );

  nftc_dp #(
    .DEPTH(CACHE_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_req   (in_req),
    .cmd      (cmd),
    .stat     (stat),
    .out_valid(out_valid),
    .out_res  (out_res)
  );

endmodule

>>> rtl/nftc_chk.sv
// Port-level checker for the frame cache, bound to the top level.
// Depends on nftc_pkg and nearest_timestamp_frame_cache_defines.svh.
`include "nearest_timestamp_frame_cache_defines.svh"

module nftc_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input nftc_pkg::nftc_res_t out_res
);

  // an accepted request keeps the block busy until its result
  `NFTC_AST_NXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")

  // a result is a single-cycle strobe
  `NFTC_AST_NXT(a_strobe_one, out_valid, !out_valid, "result strobe held longer than one cycle")

  // the end of busy is exactly where the result shows
  `NFTC_AST_IMP(a_done_result, $fell(busy), out_valid, "busy dropped without a result")

  // a miss carries a zero handle
  `NFTC_AST_IMP(a_miss_zero, out_valid && !out_res.hit, out_res.found_handle == '0,
    "miss result with nonzero handle")

endmodule

bind nearest_timestamp_frame_cache nftc_chk u_nftc_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .out_valid(out_valid),
  .out_res  (out_res)
);

>>> sim/tb_nearest_timestamp_frame_cache.sv
// Self-checking testbench for the nearest-timestamp frame cache (lookup, store, clear).
// Drives directed rows, then random requests; checks results against row values or its cache model.
// Depends on nftc_pkg and nearest_timestamp_frame_cache from the rtl folder.
module tb_nearest_timestamp_frame_cache;
  timeunit 1ns;
  timeprecision 1ps;

  import nftc_pkg::*;

  localparam int DEPTH = CACHE_DEPTH_DEF;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int ITEMS_PER_PHASE = 250;
  localparam int NUM_PHASES = 8;
  localparam int CYCLE_LIMIT = 500000;
  localparam logic [PTS_W-1:0] PTS_MIN = 48'h8000_0000_0000;
  localparam logic [PTS_W-1:0] PTS_MAX = 48'h7FFF_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]          op;
    logic [PTS_W-1:0]    pts;
    logic [HANDLE_W-1:0] handle;
    logic                present;
    logic                typed;
    logic                hit;
    logic [HANDLE_W-1:0] fh;
  } dir_row_t;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  nftc_req_t           in_req;
  logic                out_valid;
  nftc_res_t           out_res;
  logic                cfg_we;
  logic [DUR_W-1:0]    cfg_wdata;

  // cache model state
  logic [PTS_W-1:0]    cached_pts [DEPTH];
  logic [HANDLE_W-1:0] cached_handle [DEPTH];
  int                  cached_count;
  logic [DUR_W-1:0]    frame_dur;

  nftc_res_t           pending_results [$];
  nftc_res_t           want_res;
  nftc_res_t           model_res;
  bit                  typed_en;
  nftc_res_t           typed_res;
  bit                  took;
  bit                  idle_on;
  int                  mismatches;
  int                  cycle_count;

  nearest_timestamp_frame_cache #(
    .CACHE_DEPTH(DEPTH)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint sext48(input logic [PTS_W-1:0] v);
    return longint'({{(64-PTS_W){v[PTS_W-1]}}, v});
  endfunction

  function automatic longint current_tolerance();
    if (frame_dur == '0) return longint'(DEFAULT_TOL_US);
    if ((frame_dur >> 1) == '0) return 1;
    return longint'(frame_dur >> 1);
  endfunction

  // shift entries [0, slot) down by one and place the entry at the front
  function automatic void bring_to_front(input int slot, input logic [PTS_W-1:0] p,
                                         input logic [HANDLE_W-1:0] h);
    for (int i = slot; i > 0; i--) begin
      cached_pts[i] = cached_pts[i-1];
      cached_handle[i] = cached_handle[i-1];
    end
    cached_pts[0] = p;
    cached_handle[0] = h;
  endfunction

  function automatic nftc_res_t apply_frame_request(input nftc_req_t r);
    nftc_res_t res;
    longint    q;
    longint    d;
    longint    tol;
    longint    best;
    res = '0;
    case (r.req_type)
      REQ_LOOKUP: begin
        q = sext48(r.pts_us);
        tol = current_tolerance();
        best = tol + 1;
        for (int i = 0; i < cached_count; i++) begin
          d = sext48(cached_pts[i]) - q;
          if (d < 0) d = -d;
          // strict less-than keeps the more recent entry on a tie
          if (d <= tol && d < best) begin
            best = d;
            res.hit = 1'b1;
            res.found_handle = cached_handle[i];
          end
        end
      end
      REQ_STORE: begin
        if (r.image_present) begin
          for (int i = 0; i < cached_count; i++) begin
            if (cached_pts[i] == r.pts_us) begin
              bring_to_front(i, cached_pts[i], cached_handle[i]);
              return res;
            end
          end
          if (cached_count < DEPTH) begin
            bring_to_front(cached_count, r.pts_us, r.image_handle);
            cached_count++;
          end else begin
            bring_to_front(DEPTH - 1, r.pts_us, r.image_handle);
          end
        end
      end
      REQ_CLEAR: cached_count = 0;
      default: ;
    endcase
    return res;
  endfunction

  task automatic note_mismatch(input string field, input int unsigned exp_v,
                               input int unsigned act_v);
    mismatches++;
    $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, exp_v, act_v);
  endtask

  // sample handshakes and results at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      cached_count = 0;
      frame_dur = '0;
      took = 1'b0;
    end else begin
      took = (start === 1'b1) && (busy === 1'b0);
      if (out_valid === 1'b1) begin
        if (pending_results.size() == 0) begin
          note_mismatch("unexpected result", 0, out_res);
        end else begin
          want_res = pending_results.pop_front();
          if (out_res.hit !== want_res.hit)
            note_mismatch("hit", want_res.hit, out_res.hit);
          if (out_res.found_handle !== want_res.found_handle)
            note_mismatch("found_handle", want_res.found_handle, out_res.found_handle);
        end
      end
      if (cfg_we) frame_dur = cfg_wdata;
      if (took) begin
        model_res = apply_frame_request(in_req);
        pending_results.push_back(typed_en ? typed_res : model_res);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("nearest_timestamp_frame_cache regression: fail");
      $finish;
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic issue_request(input nftc_req_t r, input bit chk, input nftc_res_t res);
    if (idle_on) begin
      while ($urandom_range(0, 99) < 21) begin
        start = 1'b0;
        @(negedge clk);
      end
    end
    start = 1'b1;
    in_req = r;
    typed_en = chk;
    typed_res = res;
    do @(negedge clk); while (!took);
  endtask

  task automatic write_frame_duration(input logic [DUR_W-1:0] v);
    start = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  initial begin
    dir_row_t         rows [25];
    logic [DUR_W-1:0] phase_dur [NUM_PHASES];
    nftc_req_t        rq;
    nftc_res_t        rs;
    logic [63:0]      rnd;
    longint           tol;
    longint           off;
    longint           base;
    longint           step;
    int               sel;
    int               mode;
    int               k;
    int               k2;

    clk_init: begin end
    rst_n = 1'b0;
    start = 1'b0;
    in_req = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    typed_en = 1'b0;
    typed_res = '0;
    idle_on = 1'b1;
    mismatches = 0;
    cycle_count = 0;
    took = 1'b0;

    rows = '{
      '{REQ_LOOKUP, 48'd0,          16'h0000, 1'b0, 1'b1, 1'b0, 16'h0000},
      '{REQ_UNUSED, 48'd0,          16'h1234, 1'b1, 1'b1, 1'b0, 16'h0000},
      '{REQ_STORE,  48'd1000,       16'hAAAA, 1'b0, 1'b1, 1'b0, 16'h0000},
      '{REQ_LOOKUP, 48'd1000,       16'h0000, 1'b0, 1'b1, 1'b0, 16'h0000},
      '{REQ_STORE,  48'd1000,       16'h0001, 1'b1, 1'b1, 1'b0, 16'h0000},
      '{REQ_LOOKUP, 48'd1000,       16'h0000, 1'b0, 1'b1, 1'b1, 16'h0001},
      '{REQ_LOOKUP, 48'd21000,      16'h0000, 1'b0, 1'b1, 1'b1, 16'h0001},
      '{REQ_LOOKUP, -48'sd19000,    16'h0000, 1'b0, 1'b1, 1'b1, 16'h0001},
      '{REQ_LOOKUP, 48'd21001,      16'h0000, 1'b0, 1'b1, 1'b0, 16'h0000},
      '{REQ_STORE,  48'd3000,       16'h0002, 1'b1, 1'b1, 1'b0, 16'h0000},
      '{REQ_LOOKUP, 48'd2000,       16'h0000, 1'b0, 1'b0, 1'b0, 16'h0000},
      '{REQ_STORE,  48'd1000,       16'hFFFF, 1'b1, 1'b1, 1'b0, 16'h0000},
      '{REQ_LOOKUP, 48'd2000,       16'h0000, 1'b0, 1'b0, 1'b0, 16'h0000},
      '{REQ_STORE,  PTS_MIN,        16'h8000, 1'b1, 1'b1, 1'b0, 16'h0000},
      '{REQ_STORE,  PTS_MAX,        16'h7FFF, 1'b1, 1'b1, 1'b0, 16'h0000},
      '{REQ_LOOKUP, PTS_MIN,        16'h0000, 1'b0, 1'b0, 1'b0, 16'h0000},
      '{REQ_LOOKUP, PTS_MAX,        16'h0000, 1'b0, 1'b0, 1'b0, 16'h0000},
      '{REQ_STORE,  48'd100000,     16'h0000, 1'b1, 1'b1, 1'b0, 16'h0000},
      '{REQ_STORE,  48'd200000,     16'h1111, 1'b1, 1'b1, 1'b0, 16'h0000},
      '{REQ_STORE,  48'd300000,     16'h2222, 1'b1, 1'b1, 1'b0, 16'h0000},
      '{REQ_STORE,  48'd400000,     16'h3333, 1'b1, 1'b1, 1'b0, 16'h0000},
      '{REQ_STORE,  48'd500000,     16'h4444, 1'b1, 1'b1, 1'b0, 16'h0000},
      '{REQ_LOOKUP, 48'd3000,       16'h0000, 1'b0, 1'b0, 1'b0, 16'h0000},
      '{REQ_CLEAR,  48'd1000,       16'h5555, 1'b1, 1'b1, 1'b0, 16'h0000},
      '{REQ_LOOKUP, 48'd1000,       16'h0000, 1'b0, 1'b1, 1'b0, 16'h0000}
    };
    phase_dur = '{24'd40000, 24'd1, 24'd2, 24'd3, 24'hFFFFFF, 24'd10000000, 24'd0,
                  DUR_W'($urandom_range(4, 200000))};

    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (rows[i]) begin
      rq.req_type = rows[i].op;
      rq.pts_us = rows[i].pts;
      rq.image_handle = rows[i].handle;
      rq.image_present = rows[i].present;
      rs.hit = rows[i].hit;
      rs.found_handle = rows[i].fh;
      issue_request(rq, rows[i].typed, rs);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_frame_duration(phase_dur[ph]);
      // one whole phase back to back
      idle_on = (ph != 2);
      rnd = {$urandom, $urandom};
      base = sext48(rnd[PTS_W-1:0]);
      step = (frame_dur == '0) ? 64'sd33333 : longint'(frame_dur);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        sel = $urandom_range(0, 99);
        mode = $urandom_range(0, 9);
        tol = current_tolerance();
        rnd = {$urandom, $urandom};
        rq.pts_us = rnd[PTS_W-1:0];
        rq.image_handle = HANDLE_W'($urandom);
        rq.image_present = 1'b1;
        if (sel < 48) begin
          rq.req_type = REQ_LOOKUP;
          if (cached_count > 0 && mode < 6) begin
            k = $urandom_range(0, cached_count - 1);
            if ($urandom_range(0, 3) == 0)
              off = ($urandom_range(0, 1) ? tol : tol + 1) * ($urandom_range(0, 1) ? 1 : -1);
            else
              off = longint'($urandom_range(0, int'(2 * tol + 4))) - (tol + 2);
            rq.pts_us = PTS_W'(sext48(cached_pts[k]) + off);
          end else if (cached_count > 1 && mode < 8) begin
            // midpoint of two entries: exercises ties
            k = $urandom_range(0, cached_count - 1);
            k2 = $urandom_range(0, cached_count - 1);
            rq.pts_us = PTS_W'((sext48(cached_pts[k]) + sext48(cached_pts[k2])) >>> 1);
          end else if (mode == 9) begin
            rq.pts_us = $urandom_range(0, 1) ? PTS_MIN + $urandom_range(0, 40)
                                             : PTS_MAX - $urandom_range(0, 40);
          end
        end else if (sel < 93) begin
          rq.req_type = REQ_STORE;
          rq.image_present = (sel < 90);
          if (mode < 5) begin
            rq.pts_us = PTS_W'(base + step * longint'($urandom_range(0, 23)));
          end else if (mode < 7 && cached_count > 0) begin
            rq.pts_us = cached_pts[$urandom_range(0, cached_count - 1)];
          end else if (mode == 9) begin
            rq.pts_us = $urandom_range(0, 1) ? PTS_MIN + $urandom_range(0, 40)
                                             : PTS_MAX - $urandom_range(0, 40);
          end
        end else if (sel < 96) begin
          rq.req_type = REQ_CLEAR;
        end else begin
          rq.req_type = REQ_UNUSED;
          rq.image_present = rnd[63];
        end
        issue_request(rq, 1'b0, '0);
      end
    end

    start = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    if (mismatches == 0)
      $display("nearest_timestamp_frame_cache regression: pass");
    else
      $display("nearest_timestamp_frame_cache regression: fail");
    $finish;
  end

endmodule
